[hw/rtl/tocm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tocm_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_CITIES_DEF = 32;
  localparam int DIST_BITS_DEF  = 16;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int CITY_W   = 5;
  localparam int POS_W    = 5;
  localparam int DIN_W    = 16;
  localparam int COUNT_W  = 6;
  localparam int COST_W   = 21;
  localparam int CNT_W    = 6;

  localparam int CITY_SLOTS = 32;
  localparam int MIN_COUNT  = 5;
  localparam int MIN_CUT    = 3;

  localparam logic [COST_W-1:0]  COST_MAX      = '1;
  localparam logic [COUNT_W-1:0] COUNT_RST_VAL = 6'd32;

  // APB map: one 32-bit register, word index in paddr[2]
  localparam int   PADDR_W        = 3;
  localparam int   PDATA_W        = 32;
  localparam logic REG_CITY_COUNT = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_DIST  = 2'd0,
    CMD_LOAD_PARENT = 2'd1,
    CMD_RUN         = 2'd2
  } cmd_e;

endpackage

`default_nettype wire

[hw/rtl/tocm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write port, one registered read port.
module tocm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/tour_order_crossover_mutate_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Signals                                        | Handshake
// ----------+------------------------------------------------+-------------------------------
// command   | cmd_i, from_city_i .. swap_second_i            | taken when start_i & !busy_o
// result    | child_position_o, child_city_o, tour_cost_o,   | result_valid_o, one cycle,
//           | last_o                                         | no back-pressure
// config    | psel, penable, pwrite, paddr, pwdata, prdata   | APB, pready tied high
//
// Distance writes and parent loads never raise busy_o. A run makes five passes
// over the parent and child memories, each bounded by their single read port.
// Results of a run come back to back, the last word following the others once
// the closing edge is summed. busy_o falls with the last word.
// Reset clears control and the prefix mask; distance, parent and child memories are
// not cleared and hold garbage until written.

module tour_order_crossover_mutate_unit #(
  parameter int MAX_CITIES = tocm_pkg::MAX_CITIES_DEF,
  parameter int DIST_BITS  = tocm_pkg::DIST_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,

  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic [tocm_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [tocm_pkg::CITY_W-1:0]    from_city_i,
  input  wire logic [tocm_pkg::CITY_W-1:0]    to_city_i,
  input  wire logic [tocm_pkg::DIN_W-1:0]     distance_i,
  input  wire logic [tocm_pkg::POS_W-1:0]     position_i,
  input  wire logic [tocm_pkg::CITY_W-1:0]    city_a_i,
  input  wire logic [tocm_pkg::CITY_W-1:0]    city_b_i,
  input  wire logic [tocm_pkg::POS_W-1:0]     cut_point_i,
  input  wire logic [tocm_pkg::POS_W-1:0]     swap_first_i,
  input  wire logic [tocm_pkg::POS_W-1:0]     swap_second_i,

  output logic                                result_valid_o,
  output logic      [tocm_pkg::POS_W-1:0]     child_position_o,
  output logic      [tocm_pkg::CITY_W-1:0]    child_city_o,
  output logic      [tocm_pkg::COST_W-1:0]    tour_cost_o,
  output logic                                last_o,

  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tocm_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [tocm_pkg::PDATA_W-1:0]   pwdata,
  output logic      [tocm_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready
);

  import tocm_pkg::*;

  localparam int AW     = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int DDEPTH = MAX_CITIES * MAX_CITIES;
  localparam int DAW    = $clog2(DDEPTH);
  localparam int LIM    = (MAX_CITIES < CITY_SLOTS) ? MAX_CITIES : CITY_SLOTS;
  localparam int SUM_W  = ((DIST_BITS > COST_W) ? DIST_BITS : COST_W) + 1;
  localparam logic [6:0] MAXC = 7'(MAX_CITIES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREFIX,
    ST_SEARCH,
    ST_WALK,
    ST_SWAP,
    ST_COST
  } state_e;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e              state_q;
  logic [COUNT_W-1:0]  city_count_q;

  // run parameters, clamped at start
  logic [CNT_W-1:0]    n_q, cut_q, s1_q, s2_q;

  // read issue and stage-1 tag of the current pass
  logic                iss_q;
  logic [CNT_W-1:0]    rc_q;
  logic                v1_q, last1_q;
  logic [CNT_W-1:0]    idx1_q;

  logic [CITY_SLOTS-1:0] mask_q;
  logic [CITY_W-1:0]   key_q;
  logic                found_q;
  logic [CNT_W-1:0]    idx_q;     // B position of the key, n when absent
  logic [CNT_W-1:0]    fill_q;
  logic [CITY_W-1:0]   tmp_q;

  // cost pass, stage 2 on the distance read
  logic [CITY_W-1:0]   prev_q, lastcity_q;
  logic                v2_q, last2_q, zero2_q;
  logic [COST_W-1:0]   acc_q;

  logic                res_valid_q, res_last_q;
  logic [POS_W-1:0]    res_pos_q;
  logic [CITY_W-1:0]   res_city_q;
  logic [COST_W-1:0]   res_cost_q;

  // ---------------------------------------------------------------------------
  // Command accept and clamping
  // ---------------------------------------------------------------------------
  logic accept;
  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i & ~busy_o;

  logic [CNT_W-1:0] n_c, cut_c, s1_c, s2_c, cp_c, sf_c, ss_c, hi2_c;

  always_comb begin
    if (city_count_q < CNT_W'(MIN_COUNT)) begin
      n_c = CNT_W'(MIN_COUNT);
    end else if (city_count_q > CNT_W'(LIM)) begin
      n_c = CNT_W'(LIM);
    end else begin
      n_c = city_count_q;
    end
    hi2_c = n_c - CNT_W'(2);
    cp_c  = CNT_W'(cut_point_i);
    sf_c  = CNT_W'(swap_first_i);
    ss_c  = CNT_W'(swap_second_i);

    if (cp_c < CNT_W'(MIN_CUT)) begin
      cut_c = CNT_W'(MIN_CUT);
    end else if (cp_c > hi2_c) begin
      cut_c = hi2_c;
    end else begin
      cut_c = cp_c;
    end

    if (sf_c < CNT_W'(1)) begin
      s1_c = CNT_W'(1);
    end else if (sf_c > n_c - CNT_W'(1)) begin
      s1_c = n_c - CNT_W'(1);
    end else begin
      s1_c = sf_c;
    end

    if (ss_c < CNT_W'(1)) begin
      s2_c = CNT_W'(1);
    end else if (ss_c > hi2_c) begin
      s2_c = hi2_c;
    end else begin
      s2_c = ss_c;
    end
    // equal swap positions: second moves up by one
    if (s2_c == s1_c) begin
      s2_c = s2_c + CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  logic                 dist_we;
  logic [DAW-1:0]       dist_waddr, dist_raddr;
  logic [DIST_BITS-1:0] dist_rdata;

  logic                 par_we;
  logic [AW-1:0]        par_raddr;
  logic [2*CITY_W-1:0]  par_rdata;
  logic [CITY_W-1:0]    par_a, par_b;

  logic                 child_we;
  logic [AW-1:0]        child_waddr, child_raddr;
  logic [CITY_W-1:0]    child_wdata, child_rdata;

  assign dist_we = accept && (cmd_e'(cmd_i) == CMD_WRITE_DIST)
                   && (7'(from_city_i) < MAXC) && (7'(to_city_i) < MAXC);
  assign dist_waddr = DAW'(from_city_i) * DAW'(MAX_CITIES) + DAW'(to_city_i);

  assign par_we = accept && (cmd_e'(cmd_i) == CMD_LOAD_PARENT) && (7'(position_i) < MAXC);
  assign par_a  = par_rdata[2*CITY_W-1:CITY_W];
  assign par_b  = par_rdata[CITY_W-1:0];

  tocm_ram #(
    .WIDTH (DIST_BITS),
    .DEPTH (DDEPTH),
    .AW    (DAW)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (DIST_BITS'(distance_i)),
    .raddr_i (dist_raddr),
    .rdata_o (dist_rdata)
  );

  tocm_ram #(
    .WIDTH (2*CITY_W),
    .DEPTH (MAX_CITIES),
    .AW    (AW)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (AW'(position_i)),
    .wdata_i ({city_a_i, city_b_i}),
    .raddr_i (par_raddr),
    .rdata_o (par_rdata)
  );

  tocm_ram #(
    .WIDTH (CITY_W),
    .DEPTH (MAX_CITIES),
    .AW    (AW)
  ) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (child_waddr),
    .wdata_i (child_wdata),
    .raddr_i (child_raddr),
    .rdata_o (child_rdata)
  );

  // ---------------------------------------------------------------------------
  // Pass control: read addresses, child writes, cost adder
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] iss_end;
  logic [6:0]       walk_sum, walk_pos;
  logic             walk_wr;
  logic             city_ok_prev, city_ok_cur;
  logic [SUM_W-1:0] sum_c;
  logic [COST_W-1:0] acc_n;

  always_comb begin
    case (state_q)
      ST_PREFIX: iss_end = cut_q - CNT_W'(1);
      ST_COST:   iss_end = n_q;
      default:   iss_end = n_q - CNT_W'(1);
    endcase

    // cyclic walk through B, starting one past the key position
    walk_sum = 7'(idx_q) + 7'(rc_q);
    walk_pos = (walk_sum >= 7'(n_q)) ? walk_sum - 7'(n_q) : walk_sum;

    if (state_q == ST_WALK) begin
      par_raddr = walk_pos[AW-1:0];
    end else begin
      par_raddr = rc_q[AW-1:0];
    end

    walk_wr = (state_q == ST_WALK) && v1_q && !mask_q[par_b] && (fill_q < n_q);

    child_we    = 1'b0;
    child_waddr = idx1_q[AW-1:0];
    child_wdata = par_a;
    child_raddr = rc_q[AW-1:0];
    case (state_q)
      ST_PREFIX: begin
        child_we = v1_q;
      end
      ST_WALK: begin
        child_we    = walk_wr;
        child_waddr = fill_q[AW-1:0];
        child_wdata = par_b;
      end
      ST_SWAP: begin
        child_raddr = (rc_q == CNT_W'(0)) ? s1_q[AW-1:0] : s2_q[AW-1:0];
        if (rc_q == CNT_W'(2)) begin
          child_we    = 1'b1;
          child_waddr = s1_q[AW-1:0];
          child_wdata = child_rdata;
        end else if (rc_q == CNT_W'(3)) begin
          child_we    = 1'b1;
          child_waddr = s2_q[AW-1:0];
          child_wdata = tmp_q;
        end
      end
      ST_COST: begin
        // one extra read of position 0 closes the tour
        child_raddr = (rc_q == n_q) ? '0 : rc_q[AW-1:0];
      end
      default: ;
    endcase

    dist_raddr   = DAW'(prev_q) * DAW'(MAX_CITIES) + DAW'(child_rdata);
    city_ok_prev = 7'(prev_q) < MAXC;
    city_ok_cur  = 7'(child_rdata) < MAXC;

    // saturating accumulate; all terms are non-negative
    sum_c = SUM_W'(acc_q) + (zero2_q ? '0 : SUM_W'(dist_rdata));
    acc_n = (sum_c > SUM_W'(COST_MAX)) ? COST_MAX : sum_c[COST_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      city_count_q <= COUNT_RST_VAL;
      n_q          <= CNT_W'(LIM);
      cut_q        <= CNT_W'(MIN_CUT);
      s1_q         <= CNT_W'(1);
      s2_q         <= CNT_W'(2);
      iss_q        <= 1'b0;
      rc_q         <= '0;
      v1_q         <= 1'b0;
      last1_q      <= 1'b0;
      idx1_q       <= '0;
      mask_q       <= '0;
      key_q        <= '0;
      found_q      <= 1'b0;
      idx_q        <= '0;
      fill_q       <= '0;
      tmp_q        <= '0;
      prev_q       <= '0;
      lastcity_q   <= '0;
      v2_q         <= 1'b0;
      last2_q      <= 1'b0;
      zero2_q      <= 1'b0;
      acc_q        <= '0;
      res_valid_q  <= 1'b0;
      res_last_q   <= 1'b0;
      res_pos_q    <= '0;
      res_city_q   <= '0;
      res_cost_q   <= '0;
    end else begin
      res_valid_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;

      if (psel && penable && pwrite && (paddr[2] == REG_CITY_COUNT)) begin
        city_count_q <= pwdata[COUNT_W-1:0];
      end

      // read issue, shared by the streaming passes
      if (iss_q) begin
        v1_q    <= 1'b1;
        idx1_q  <= rc_q;
        last1_q <= (rc_q == iss_end);
        rc_q    <= rc_q + CNT_W'(1);
        if (rc_q == iss_end) begin
          iss_q <= 1'b0;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (accept && (cmd_e'(cmd_i) == CMD_RUN)) begin
            n_q     <= n_c;
            cut_q   <= cut_c;
            s1_q    <= s1_c;
            s2_q    <= s2_c;
            fill_q  <= cut_c;
            idx_q   <= n_c;
            found_q <= 1'b0;
            mask_q  <= '0;
            acc_q   <= '0;
            rc_q    <= '0;
            iss_q   <= 1'b1;
            state_q <= ST_PREFIX;
          end
        end

        ST_PREFIX: begin
          if (v1_q) begin
            mask_q[par_a] <= 1'b1;
            if (last1_q) begin
              key_q   <= par_a;
              rc_q    <= '0;
              iss_q   <= 1'b1;
              state_q <= ST_SEARCH;
            end
          end
        end

        ST_SEARCH: begin
          if (v1_q) begin
            if (!found_q && (par_b == key_q)) begin
              found_q <= 1'b1;
              idx_q   <= idx1_q;
            end
            if (last1_q) begin
              rc_q    <= CNT_W'(1);
              iss_q   <= 1'b1;
              state_q <= ST_WALK;
            end
          end
        end

        ST_WALK: begin
          if (walk_wr) begin
            fill_q <= fill_q + CNT_W'(1);
          end
          if (v1_q && last1_q) begin
            rc_q    <= '0;
            state_q <= ST_SWAP;
          end
        end

        ST_SWAP: begin
          rc_q <= rc_q + CNT_W'(1);
          if (rc_q == CNT_W'(1)) begin
            tmp_q <= child_rdata;
          end
          if (rc_q == CNT_W'(3)) begin
            rc_q    <= '0;
            iss_q   <= 1'b1;
            state_q <= ST_COST;
          end
        end

        ST_COST: begin
          if (v1_q) begin
            prev_q <= child_rdata;
            if (idx1_q != '0) begin
              v2_q    <= 1'b1;
              last2_q <= last1_q;
              zero2_q <= !(city_ok_prev && city_ok_cur);
            end
            if (idx1_q < n_q - CNT_W'(1)) begin
              res_valid_q <= 1'b1;
              res_pos_q   <= idx1_q[POS_W-1:0];
              res_city_q  <= child_rdata;
              res_cost_q  <= '0;
              res_last_q  <= 1'b0;
            end
            if (idx1_q == n_q - CNT_W'(1)) begin
              lastcity_q <= child_rdata;
            end
          end
          if (v2_q) begin
            acc_q <= acc_n;
            if (last2_q) begin
              res_valid_q <= 1'b1;
              res_pos_q   <= POS_W'(n_q - CNT_W'(1));
              res_city_q  <= lastcity_q;
              res_cost_q  <= acc_n;
              res_last_q  <= 1'b1;
              state_q     <= ST_IDLE;
            end
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o   = res_valid_q;
  assign child_position_o = res_pos_q;
  assign child_city_o     = res_city_q;
  assign tour_cost_o      = res_cost_q;
  assign last_o           = res_last_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CITY_COUNT) ? PDATA_W'(city_count_q) : '0;

`ifndef NO_ASSERTIONS
  // the closing word is the only one shown after the run has ended
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (last_o == !busy_o))
    else $error("last word and busy out of step");

  a_run_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i == CMD_RUN)) |=> busy_o)
    else $error("run accepted without going busy");

  a_swap_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (s1_q != s2_q) && (s2_q < n_q) && (s1_q < n_q))
    else $error("swap positions collide or exceed tour");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (fill_q <= n_q))
    else $error("child fill beyond tour length");
`endif

endmodule

`default_nettype wire

[dv/tb_tour_order_crossover_mutate_unit.sv]
`timescale 1ns / 1ps

// Ordered crossover / swap mutation unit testbench.
// The distance table and both parents are filled first, so that no run ever reads
// an entry that was never written. The first run at 32 cities then fills the
// whole child tour. After that come a short directed table and random phases.
// Each phase sets city_count over the APB port and sets a sender gap rate.
// Every accepted command word goes through a local model of the unit. The child
// words it predicts are queued and compared in order with what comes out.

module tb_tour_order_crossover_mutate_unit;
  import tocm_pkg::*;

  localparam logic [CMD_W-1:0]   CMD_IGNORED     = 2'd3;
  localparam logic [PADDR_W-1:0] CITY_COUNT_ADDR = {REG_CITY_COUNT, 2'b00};
  localparam int WATCHDOG_LIMIT = 4000;  // a 32-city run is quiet until its child words come out
  localparam int PHASE_WORDS    = 60;
  localparam int N_DIRECTED     = 17;
  localparam int N_PHASES       = 6;
  localparam int CFG_PLAN [N_PHASES] = '{63, 5, 0, 19, 33, 32};
  localparam int GAP_PLAN [N_PHASES] = '{0, 49, 29, 0, 49, 29};

  // one command word, field order as on the ports
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CITY_W-1:0] from_city;
    logic [CITY_W-1:0] to_city;
    logic [DIN_W-1:0]  distance;
    logic [POS_W-1:0]  position;
    logic [CITY_W-1:0] city_a;
    logic [CITY_W-1:0] city_b;
    logic [POS_W-1:0]  cut_point;
    logic [POS_W-1:0]  swap_first;
    logic [POS_W-1:0]  swap_second;
  } cmd_word_t;

  // directed row: a word, plus a tour cost typed in where it is obvious
  typedef struct packed {
    cmd_word_t         w;
    logic              cost_known;
    logic [COST_W-1:0] cost;
  } stim_row_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CITY_W-1:0] city;
    logic [COST_W-1:0] cost;
    logic              last;
  } child_word_t;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy_o;
  logic [CMD_W-1:0]     cmd;
  logic [CITY_W-1:0]    from_city, to_city, city_a, city_b;
  logic [DIN_W-1:0]     distance;
  logic [POS_W-1:0]     position, cut_point, swap_first, swap_second;
  logic                 result_valid_o;
  logic [POS_W-1:0]     child_position_o;
  logic [CITY_W-1:0]    child_city_o;
  logic [COST_W-1:0]    tour_cost_o;
  logic                 last_o;
  logic                 psel, penable, pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata, prdata;
  logic                 pready;

  tour_order_crossover_mutate_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_o           (busy_o),
    .cmd_i            (cmd),
    .from_city_i      (from_city),
    .to_city_i        (to_city),
    .distance_i       (distance),
    .position_i       (position),
    .city_a_i         (city_a),
    .city_b_i         (city_b),
    .cut_point_i      (cut_point),
    .swap_first_i     (swap_first),
    .swap_second_i    (swap_second),
    .result_valid_o   (result_valid_o),
    .child_position_o (child_position_o),
    .child_city_o     (child_city_o),
    .tour_cost_o      (tour_cost_o),
    .last_o           (last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 4 ns clock, first rising edge at 2 ns
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Local copy of the unit's state
  // ---------------------------------------------------------------------------
  logic [DIN_W-1:0]   dist_tbl [CITY_SLOTS][CITY_SLOTS];
  logic [CITY_W-1:0]  par_a [CITY_SLOTS];
  logic [CITY_W-1:0]  par_b [CITY_SLOTS];
  logic [CITY_W-1:0]  child [CITY_SLOTS];
  logic [COUNT_W-1:0] count_reg = COUNT_RST_VAL;

  child_word_t child_words_due [$];

  // parents drawn for the next load sequence
  logic [CITY_W-1:0]  draw_a [CITY_SLOTS];
  logic [CITY_W-1:0]  draw_b [CITY_SLOTS];

  int gap_pct        = 0;
  int words_sent     = 0;
  int runs_sent      = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int stall_cycles   = 0;

  function automatic int clamp_to(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // city_count is used saturated to 5..32
  function automatic int active_count();
    return clamp_to(int'(count_reg), MIN_COUNT, CITY_SLOTS);
  endfunction

  // Advance the local state by one accepted word and queue the child words of a run.
  // With the default 32-city build no index can be out of range, so those guards fall away.
  task automatic apply_word(input cmd_word_t w);
    int n, cut, idx, fill, s1, s2, cost;
    logic [CITY_W-1:0] key, c, tmp;
    bit in_prefix [CITY_SLOTS];
    child_word_t cw;
    case (w.cmd)
      CMD_WRITE_DIST: dist_tbl[w.from_city][w.to_city] = w.distance;
      CMD_LOAD_PARENT: begin
        par_a[w.position] = w.city_a;
        par_b[w.position] = w.city_b;
      end
      CMD_RUN: begin
        n   = active_count();
        cut = clamp_to(int'(w.cut_point), MIN_CUT, n - 2);
        foreach (in_prefix[i]) in_prefix[i] = 1'b0;
        for (int i = 0; i < cut; i++) begin
          child[i] = par_a[i];
          in_prefix[par_a[i]] = 1'b1;
        end
        // walk B from just past the last prefix city; from position 1 if B lacks it
        key = child[cut - 1];
        idx = n;
        for (int i = 0; i < n; i++) begin
          if (idx == n && par_b[i] == key) idx = i;
        end
        fill = cut;
        for (int k = 1; k < n; k++) begin
          c = par_b[(idx + k) % n];
          if (!in_prefix[c] && fill < n) begin
            child[fill] = c;
            fill++;
          end
        end
        // swap mutation; equal indices push the second one up
        s1 = clamp_to(int'(w.swap_first), 1, n - 1);
        s2 = clamp_to(int'(w.swap_second), 1, n - 2);
        if (s2 == s1) s2++;
        tmp = child[s1];
        child[s1] = child[s2];
        child[s2] = tmp;
        // closed tour cost, closing edge included
        cost = dist_tbl[child[n - 1]][child[0]];
        for (int i = 1; i < n; i++) cost += dist_tbl[child[i - 1]][child[i]];
        if (cost > int'(COST_MAX)) cost = int'(COST_MAX);
        for (int i = 0; i < n; i++) begin
          cw.pos  = POS_W'(i);
          cw.city = child[i];
          cw.cost = (i == n - 1) ? COST_W'(cost) : '0;
          cw.last = (i == n - 1);
          child_words_due.push_back(cw);
        end
        runs_sent++;
      end
      default: ;  // ignored command
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Word builders: unused fields carry random bits
  // ---------------------------------------------------------------------------
  function automatic cmd_word_t rand_word();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return bits[$bits(cmd_word_t)-1:0];
  endfunction

  function automatic cmd_word_t mk_dist(input logic [CITY_W-1:0] f, t,
                                        input logic [DIN_W-1:0] d);
    cmd_word_t w;
    w = rand_word();
    w.cmd = CMD_WRITE_DIST;
    w.from_city = f;
    w.to_city = t;
    w.distance = d;
    return w;
  endfunction

  function automatic cmd_word_t mk_load(input logic [POS_W-1:0] p,
                                        input logic [CITY_W-1:0] a, b);
    cmd_word_t w;
    w = rand_word();
    w.cmd = CMD_LOAD_PARENT;
    w.position = p;
    w.city_a = a;
    w.city_b = b;
    return w;
  endfunction

  function automatic cmd_word_t mk_run(input logic [POS_W-1:0] cut, s1, s2);
    cmd_word_t w;
    w = rand_word();
    w.cmd = CMD_RUN;
    w.cut_point = cut;
    w.swap_first = s1;
    w.swap_second = s2;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side driver: drive at the falling edge, taken at a rising edge
  // where start is high and busy is low.
  // ---------------------------------------------------------------------------
  task automatic send_word(input cmd_word_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start       = 1'b1;
    cmd         = w.cmd;
    from_city   = w.from_city;
    to_city     = w.to_city;
    distance    = w.distance;
    position    = w.position;
    city_a      = w.city_a;
    city_b      = w.city_b;
    cut_point   = w.cut_point;
    swap_first  = w.swap_first;
    swap_second = w.swap_second;
    do @(posedge clk_i); while (busy_o);
    apply_word(w);
    if (w.cmd != CMD_IGNORED) words_sent++;
  endtask

  // drop start, let every queued child word arrive, then the extra quiet cycles
  task automatic drain(input int extra);
    @(negedge clk_i);
    start = 1'b0;
    while (child_words_due.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic apb_cycle(input logic wr, input logic [PDATA_W-1:0] wdata,
                           output logic [PDATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = CITY_COUNT_ADDR;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // write city_count (upper data bits random, only 6 are kept) and read it back
  task automatic set_city_count(input logic [COUNT_W-1:0] v);
    logic [PDATA_W-1:0] wdata, rdata;
    wdata = $urandom();
    wdata[COUNT_W-1:0] = v;
    apb_cycle(1'b1, wdata, rdata);
    count_reg = v;
    apb_cycle(1'b0, $urandom(), rdata);
    if (rdata !== PDATA_W'(v)) begin
      $display("%0t: city_count readback mismatch, expected %0d, got %0d",
               $time, v, rdata);
      mismatches++;
    end
  endtask

  // two random parents over the same random set of n cities
  task automatic draw_parents(input int n);
    int j;
    logic [CITY_W-1:0] t;
    for (int i = 0; i < CITY_SLOTS; i++) draw_a[i] = CITY_W'(i);
    for (int i = CITY_SLOTS - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = draw_a[i]; draw_a[i] = draw_a[j]; draw_a[j] = t;
    end
    draw_b = draw_a;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = draw_b[i]; draw_b[i] = draw_b[j]; draw_b[j] = t;
    end
  endtask

  task automatic load_parents(input int n);
    for (int p = 0; p < n; p++) send_word(mk_load(POS_W'(p), draw_a[p], draw_b[p]));
  endtask

  // Mostly clean parent pairs followed by runs. The rest is broken parents
  // (random B, or stray position rewrites), with ignored words and distance
  // rewrites mixed in.
  task automatic random_phase();
    int first, n, r, reps;
    cmd_word_t w;
    first = words_sent;
    n = active_count();
    while (words_sent - first < PHASE_WORDS) begin
      r = $urandom_range(99);
      draw_parents(n);
      if (r < 65) begin
        load_parents(n);
      end else if (r < 82) begin
        for (int p = 0; p < n; p++) draw_b[p] = CITY_W'($urandom_range(31));
        load_parents(n);
      end else begin
        reps = $urandom_range(4, 1);
        for (int i = 0; i < reps; i++)
          send_word(mk_load(POS_W'($urandom_range(31)), CITY_W'($urandom_range(31)),
                            CITY_W'($urandom_range(31))));
      end
      reps = $urandom_range(2);
      for (int i = 0; i < reps; i++)
        send_word(mk_dist(CITY_W'($urandom_range(31)), CITY_W'($urandom_range(31)),
                          DIN_W'($urandom())));
      if ($urandom_range(3) == 0) begin
        w = rand_word();
        w.cmd = CMD_IGNORED;
        send_word(w);
      end
      reps = $urandom_range(3, 1);
      for (int i = 0; i < reps; i++)
        send_word(mk_run(POS_W'($urandom_range(31)), POS_W'($urandom_range(31)),
                         POS_W'($urandom_range(31))));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: each strobed child word against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic report_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    child_word_t exp_w;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (child_words_due.size() == 0) begin
        $display("%0t: unexpected child word, got position %0d city %0d cost %0d last %0b",
                 $time, child_position_o, child_city_o, tour_cost_o, last_o);
        mismatches++;
      end else begin
        exp_w = child_words_due.pop_front();
        report_field("child_position", exp_w.pos, child_position_o);
        report_field("child_city", exp_w.city, child_city_o);
        report_field("tour_cost", exp_w.cost, tour_cost_o);
        report_field("last", exp_w.last, last_o);
      end
    end
  end

  // watchdog: cycles in which no command, child word or APB access went through
  always @(posedge clk_i) begin
    if ((start && !busy_o) || result_valid_o || (psel && penable)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, nothing accepted for %0d cycles, %0d child words pending",
               $time, WATCHDOG_LIMIT, child_words_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  stim_row_t directed_words [N_DIRECTED];

  initial begin
    stim_row_t   row;
    child_word_t cw;

    rst_ni      = 1'b0;
    start       = 1'b0;
    cmd         = CMD_WRITE_DIST;
    from_city   = '0;
    to_city     = '0;
    distance    = '0;
    position    = '0;
    city_a      = '0;
    city_b      = '0;
    cut_point   = '0;
    swap_first  = '0;
    swap_second = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;

    // Directed rows. The parents at this point are A = 0..31 and B = 31..0.
    // Every distance is 16'hFFFF, so the first full tour costs 32 * 65535.
    directed_words[0]  = '{mk_run(5'd0, 5'd0, 5'd0), 1'b1, 21'd2097120}; // all low clamps
    directed_words[1]  = '{cmd_word_t'('1), 1'b0, '0};                   // ignored, all ones
    directed_words[2]  = '{mk_dist(5'd31, 5'd0, 16'h0000), 1'b0, '0};
    directed_words[3]  = '{mk_dist(5'd0, 5'd31, 16'h0000), 1'b0, '0};
    directed_words[4]  = '{mk_dist(5'd31, 5'd31, 16'hFFFF), 1'b0, '0};
    directed_words[5]  = '{mk_dist(5'd0, 5'd0, 16'h0000), 1'b0, '0};
    directed_words[6]  = '{mk_run(5'd31, 5'd31, 5'd31), 1'b0, '0};        // high clamps on cut and second swap
    directed_words[7]  = '{mk_run(5'd5, 5'd5, 5'd5), 1'b0, '0};           // equal swap bump
    directed_words[8]  = '{mk_run(5'd4, 5'd31, 5'd0), 1'b0, '0};
    directed_words[9]  = '{mk_load(5'd28, 5'd28, 5'd4), 1'b0, '0};        // B drops city 3
    directed_words[10] = '{mk_run(5'd4, 5'd2, 5'd9), 1'b0, '0};           // key city not in B
    directed_words[11] = '{mk_load(5'd31, 5'd31, 5'd31), 1'b0, '0};
    directed_words[12] = '{mk_load(5'd0, 5'd0, 5'd0), 1'b0, '0};
    directed_words[13] = '{mk_run(5'd3, 5'd0, 5'd31), 1'b0, '0};
    directed_words[14] = '{mk_load(5'd5, 5'd5, 5'd0), 1'b0, '0};          // short fill, stale tail
    directed_words[15] = '{mk_run(5'd0, 5'd31, 5'd1), 1'b0, '0};
    directed_words[16] = '{mk_run(5'd31, 5'd1, 5'd31), 1'b0, '0};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill the distance and parent stores once: distances at the top value, parents 0..31 / 31..0
    for (int f = 0; f < CITY_SLOTS; f++)
      for (int t = 0; t < CITY_SLOTS; t++)
        send_word(mk_dist(CITY_W'(f), CITY_W'(t), 16'hFFFF));
    for (int p = 0; p < CITY_SLOTS; p++)
      send_word(mk_load(POS_W'(p), CITY_W'(p), CITY_W'(CITY_SLOTS - 1 - p)));

    // the first row is a full 32-city run, so the child tour is written before any
    // later run can leave positions unfilled
    foreach (directed_words[i]) begin
      row = directed_words[i];
      send_word(row.w);
      if (row.cost_known) begin
        cw = child_words_due.pop_back();
        cw.cost = row.cost;
        child_words_due.push_back(cw);
      end
    end

    // random distances for the random phases
    for (int f = 0; f < CITY_SLOTS; f++)
      for (int t = 0; t < CITY_SLOTS; t++)
        send_word(mk_dist(CITY_W'(f), CITY_W'(t), DIN_W'($urandom())));

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain(4);  // loads and distance writes never raise busy
      set_city_count(COUNT_W'(CFG_PLAN[ph]));
      gap_pct = GAP_PLAN[ph];
      random_phase();
    end

    drain(40);
    $display("Covered %0d commands incl. %0d crossover runs, %0d child words checked,",
             words_sent, runs_sent, results_seen);
    $display("city_count written as 63, 5, 0, 19, 33, 32; sender gaps of 0, 29 and 49%%");
    if (mismatches == 0 && child_words_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/tocm_pkg.sv
hw/rtl/tocm_ram.sv
hw/rtl/tour_order_crossover_mutate_unit.sv
dv/tb_tour_order_crossover_mutate_unit.sv
